### hw/rtl/bmf_pkg.sv
// Shared types and constants for the binned mode finder.
package bmf_pkg;

  localparam int BIN_SLOTS  = 64;
  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SAMPLE_W   = 32;
  localparam int EXP_W      = 7;
  localparam int IDX_W      = (BIN_SLOTS > 1) ? $clog2(BIN_SLOTS) : 1;
  localparam int EXP_MAX    = 32;
  localparam int EXP_MIN    = -32;
  // widest key is the sample shifted left by EXP_MAX - FRAC_BITS
  localparam int KEY_W      = SAMPLE_W + EXP_MAX - FRAC_BITS;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_set;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mode_sample;
    logic                       run_last;
    logic                       table_overflow;
  } out_beat_t;

  // One bin as held by a cell
  typedef struct packed {
    logic                       valid;
    key_t                       key;
    count_t                     count;
    logic signed [SAMPLE_W-1:0] first;
  } entry_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic load;
    logic alloc_ok;
    logic rotate;
    logic clear;
  } cell_ctl_t;

endpackage

### hw/rtl/bmf_cell.sv
// One bin cell: key match, count, allocate, rotate to neighbor.
module bmf_cell import bmf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctl_t                  ctl,
  input  key_t                       key_in,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       prev_valid,
  input  entry_t                     nbr_in,
  output entry_t                     entry,
  output logic                       hit
);

  entry_t entry_r, entry_nxt;

  assign entry = entry_r;
  assign hit   = entry_r.valid && (entry_r.key == key_in);

  // next cell contents
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.clear) begin
      entry_nxt.valid = 1'b0;
      entry_nxt.count = '0;
    end else if (ctl.rotate) begin
      entry_nxt = nbr_in;
    end else if (ctl.load) begin
      if (hit) begin
        if (entry_r.count != {COUNT_BITS{1'b1}})
          entry_nxt.count = entry_r.count + 1'b1;
      end else if (!entry_r.valid && prev_valid && ctl.alloc_ok) begin
        // lowest free cell takes the new key
        entry_nxt.valid = 1'b1;
        entry_nxt.key   = key_in;
        entry_nxt.count = count_t'(1);
        entry_nxt.first = sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      entry_r.count <= '0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
      entry_r.count <= entry_nxt.count;
    end
    entry_r.key   <= entry_nxt.key;
    entry_r.first <= entry_nxt.first;
  end

endmodule

### hw/rtl/bmf_chain.sv
// Row of bin cells with hit collection and a rotating ring for scans.
module bmf_chain import bmf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       rotate,
  input  logic                       clear,
  input  key_t                       key_in,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output entry_t                     head,
  output logic                       any_hit,
  output logic                       full
);

  entry_t                 ent [BIN_SLOTS];
  logic [BIN_SLOTS-1:0]   hits;
  cell_ctl_t              ctl;

  assign any_hit      = |hits;
  assign ctl.load     = load;
  assign ctl.alloc_ok = !any_hit;
  assign ctl.rotate   = rotate;
  assign ctl.clear    = clear;
  assign head         = ent[0];
  assign full         = ent[BIN_SLOTS-1].valid;

  for (genvar i = 0; i < BIN_SLOTS; i++) begin : g_cell
    bmf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key_in     (key_in),
      .sample_in  (sample_in),
      .prev_valid ((i == 0) ? 1'b1 : ent[(i == 0) ? 0 : i-1].valid),
      .nbr_in     (ent[(i + 1) % BIN_SLOTS]),
      .entry      (ent[i]),
      .hit        (hits[i])
    );
  end

endmodule

### hw/rtl/binned_mode_finder_top.sv
// Top level of the binned mode finder: key front end, cell row, mode scan.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  input   | start, busy, in_data           | beat taken when start & !busy
//  result  | out_valid, out_data            | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | write when cfg_valid & cfg_ready
//
// Samples are taken one per cycle while busy is low; each is keyed and
// matched against all cells in the next cycle. After the end-of-set
// sample, busy stays high while it is counted, through a max-count scan,
// then one selection scan per modal bin plus a final one, and a clear
// state. Results leave in ascending key order. Reset empties the table.
module binned_mode_finder_top import bmf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  in_beat_t                in_data,
  output logic                    out_valid,
  output out_beat_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic signed [EXP_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAX  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic signed [EXP_W-1:0]    exp_r;
  logic [2:0]                 state_r, state_nxt;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;
  logic                       s1_valid_r, s1_last_r;
  key_t                       s1_key_r;
  logic signed [SAMPLE_W-1:0] s1_samp_r;
  count_t                     best_r, best_nxt;
  logic                       found_r, found_nxt;
  key_t                       min_key_r, min_key_nxt;
  logic signed [SAMPLE_W-1:0] min_samp_r, min_samp_nxt;
  logic                       have_prev_r, have_prev_nxt;
  key_t                       prev_key_r, prev_key_nxt;
  logic                       pend_r, pend_nxt;
  logic signed [SAMPLE_W-1:0] pend_samp_r, pend_samp_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_beat_t                  out_data_r, out_data_nxt;

  logic                       accept;
  logic signed [EXP_W-1:0]    exp_c, shamt;
  key_t                       samp_ext, key_c;
  entry_t                     head;
  logic                       any_hit, full, load, pass_end, cand;

  assign accept    = start && !busy;
  assign busy      = (s1_valid_r && s1_last_r) || (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // key = floor(sample * 2^exp) as a shift by exp - FRAC_BITS
  always_comb begin
    exp_c = exp_r;
    if (exp_r > EXP_W'(EXP_MAX)) exp_c = EXP_W'(EXP_MAX);
    if (exp_r < EXP_W'(EXP_MIN)) exp_c = EXP_W'(EXP_MIN);
    shamt    = exp_c - EXP_W'(FRAC_BITS);
    samp_ext = KEY_W'(in_data.sample);
    if (shamt >= 0) key_c = samp_ext <<< shamt[5:0];
    else            key_c = samp_ext >>> 6'(-shamt);
  end

  // config register and front-end stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) exp_r <= cfg_data;
      s1_valid_r <= accept;
      s1_last_r  <= accept && in_data.end_of_set;
    end
    s1_key_r  <= key_c;
    s1_samp_r <= in_data.sample;
  end

  assign load = s1_valid_r && (state_r == ST_IDLE);

  bmf_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .rotate    ((state_r == ST_MAX) || (state_r == ST_SEL)),
    .clear     (state_r == ST_CLR),
    .key_in    (s1_key_r),
    .sample_in (s1_samp_r),
    .head      (head),
    .any_hit   (any_hit),
    .full      (full)
  );

  assign pass_end = (cnt_r == IDX_W'(BIN_SLOTS - 1));
  assign cand = head.valid && (head.count == best_r)
             && (!have_prev_r || (head.key > prev_key_r))
             && (!found_r || (head.key < min_key_r));

  // scan controller
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    min_key_nxt   = min_key_r;
    min_samp_nxt  = min_samp_r;
    have_prev_nxt = have_prev_r;
    prev_key_nxt  = prev_key_r;
    pend_nxt      = pend_r;
    pend_samp_nxt = pend_samp_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (load && !any_hit && full) ovf_nxt = 1'b1;
        if (s1_valid_r && s1_last_r) begin
          state_nxt = ST_MAX;
          cnt_nxt   = '0;
          best_nxt  = '0;
        end
      end
      ST_MAX: begin
        if (head.valid && (head.count > best_r)) best_nxt = head.count;
        cnt_nxt = cnt_r + 1'b1;
        if (pass_end) begin
          state_nxt = ST_SEL;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SEL: begin
        if (cand) begin
          found_nxt    = 1'b1;
          min_key_nxt  = head.key;
          min_samp_nxt = head.first;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (pass_end) begin
          state_nxt = ST_DEC;
          cnt_nxt   = '0;
        end
      end
      ST_DEC: begin
        // emit the held bin one pass late so the final one gets run_last
        out_data_nxt.mode_sample    = pend_samp_r;
        out_data_nxt.table_overflow = ovf_r;
        if (found_r) begin
          out_valid_nxt         = pend_r;
          out_data_nxt.run_last = 1'b0;
          pend_nxt      = 1'b1;
          pend_samp_nxt = min_samp_r;
          have_prev_nxt = 1'b1;
          prev_key_nxt  = min_key_r;
          found_nxt     = 1'b0;
          state_nxt     = ST_SEL;
        end else begin
          out_valid_nxt         = pend_r;
          out_data_nxt.run_last = 1'b1;
          state_nxt             = ST_CLR;
        end
      end
      ST_CLR: begin
        have_prev_nxt = 1'b0;
        pend_nxt      = 1'b0;
        ovf_nxt       = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      have_prev_r <= 1'b0;
      pend_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      have_prev_r <= have_prev_nxt;
      pend_r      <= pend_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    best_r      <= best_nxt;
    min_key_r   <= min_key_nxt;
    min_samp_r  <= min_samp_nxt;
    prev_key_r  <= prev_key_nxt;
    pend_samp_r <= pend_samp_nxt;
    out_data_r  <= out_data_nxt;
  end

  // results only come out during a run
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a run");

  // end of set locks the input
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.end_of_set) |=> busy) else $error("no busy after last");

  // nothing follows the run's last beat
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.run_last) |=> !out_valid) else $error("beat after last");

endmodule
